FILE: rtl/mtws_pkg.sv
// Shared constants, codes and types of the multicore tick wakeup scheduler.
package mtws_pkg;

   localparam int NUM_CORES    = 8;
   localparam int COUNT_WIDTH  = 32;
   localparam int CORE_W       = 3;
   localparam int OP_W         = 2;
   localparam int DELAY_W      = 16;
   localparam int VEC_W        = 8;
   localparam int SLOW_W       = 32;
   localparam int ACTIVE_W     = 4;
   localparam int SLOW_DIVISOR = 100;
   localparam int RES_W        = $clog2(SLOW_DIVISOR);

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(8);
   localparam logic [RES_W-1:0]    RES_LAST     = RES_W'(SLOW_DIVISOR - 1);

   // Operation codes carried in the request's tuser.
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_OTHER = 2'd1;
   localparam logic [OP_W-1:0] OP_ARM   = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

   // Request tdata layout, lowest field first.
   localparam int REQ_DATA_W = 32;
   localparam int REQ_CORE_LO  = 0;
   localparam int REQ_SRC_LO   = REQ_CORE_LO + CORE_W;
   localparam int REQ_DELAY_LO = REQ_SRC_LO + CORE_W;
   localparam int REQ_VEC_LO   = REQ_DELAY_LO + DELAY_W;

   // Response tdata layout, lowest field first.
   localparam int RSP_DATA_W = 80;
   localparam int RSP_TGT_LO   = 0;
   localparam int RSP_VEC_LO   = RSP_TGT_LO + CORE_W;
   localparam int RSP_TICKS_LO = RSP_VEC_LO + VEC_W;
   localparam int RSP_SLOW_LO  = RSP_TICKS_LO + COUNT_WIDTH;
   localparam int RSP_USED_W   = RSP_SLOW_LO + SLOW_W;

   // Scan token that walks down the row of cells.
   typedef struct packed {
      logic                   valid;
      logic [CORE_W-1:0]      core;
      logic [COUNT_WIDTH-1:0] now;
   } scan_type;

   // Update of one cell's state.
   typedef struct packed {
      logic                   arm;
      logic                   clear;
      logic                   tick;
      logic [COUNT_WIDTH-1:0] wake_time;
      logic [CORE_W-1:0]      source;
      logic [VEC_W-1:0]       vector;
      logic [COUNT_WIDTH-1:0] count;
      logic [RES_W-1:0]       residue;
   } cell_wr_type;

   // Wakeup found by a cell; zero when there is none.
   typedef struct packed {
      logic              hit;
      logic [CORE_W-1:0] target;
      logic [VEC_W-1:0]  vector;
   } hit_type;

endpackage

FILE: rtl/mtws_cell.sv
// One core's tick counter and wakeup entry, with one stage of the scan chain.
module mtws_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [mtws_pkg::CORE_W-1:0]      cell_index,
   input  logic [mtws_pkg::ACTIVE_W-1:0]    active_cores,
   input  logic                            wr_en,
   input  mtws_pkg::cell_wr_type           wr,
   input  logic                            advance,
   input  mtws_pkg::scan_type              scan_in,
   output mtws_pkg::scan_type              scan_out,
   output mtws_pkg::hit_type               hit,
   output logic [mtws_pkg::COUNT_WIDTH-1:0] count,
   output logic [mtws_pkg::RES_W-1:0]       residue
);
   import mtws_pkg::*;

   logic [COUNT_WIDTH-1:0] time_ff, time_in;
   logic [CORE_W-1:0]      source_ff, source_in;
   logic [VEC_W-1:0]       vector_ff, vector_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [RES_W-1:0]       residue_ff, residue_in;
   scan_type               scan_ff, scan_in_nxt;

   always_comb begin
      time_in    = time_ff;
      source_in  = source_ff;
      vector_in  = vector_ff;
      count_in   = count_ff;
      residue_in = residue_ff;
      if (wr_en) begin
         if (wr.arm) begin
            time_in   = wr.wake_time;
            source_in = wr.source;
            vector_in = wr.vector;
         end
         if (wr.clear) begin
            time_in   = '0;
            source_in = '0;
         end
         if (wr.tick) begin
            count_in   = wr.count;
            residue_in = wr.residue;
         end
      end
   end

   assign scan_in_nxt = advance ? scan_in : scan_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         source_ff     <= '0;
         vector_ff     <= '0;
         count_ff      <= '0;
         residue_ff    <= '0;
         scan_ff.valid <= 1'b0;
         scan_ff.core  <= '0;
         scan_ff.now   <= '0;
      end else begin
         time_ff    <= time_in;
         source_ff  <= source_in;
         vector_ff  <= vector_in;
         count_ff   <= count_in;
         residue_ff <= residue_in;
         scan_ff    <= scan_in_nxt;
      end
   end

   // The entry wakes when the ticking core times it, it is not the ticking
   // core itself, it lies inside the scanned range and its time has passed.
   logic match;
   assign match = scan_in.valid
                  && (source_ff == scan_in.core)
                  && (cell_index != scan_in.core)
                  && ({1'b0, cell_index} < active_cores)
                  && (time_ff < scan_in.now);

   assign hit.hit    = match;
   assign hit.target = match ? cell_index : '0;
   assign hit.vector = match ? vector_ff : '0;

   assign scan_out = scan_ff;
   assign count    = count_ff;
   assign residue  = residue_ff;

endmodule

FILE: rtl/multicore_tick_wakeup_scheduler.sv
// Top level of the multicore tick wakeup scheduler: request decode, cell row and result output.
//
// Arm, clear and other-interrupt items give no result. A timer tick first
// updates the ticking core's counter, then a scan token walks the row of
// core cells one cell per cycle, and a final step closes the tick with its
// last result. Results come out in increasing target order, one per woken
// core, or a single result with ipi_valid low when no core wakes; the scan
// pauses while the output register is full. A new request is taken only
// after the last result of a tick has been loaded into the output register.
// The configuration write port is always ready.
module multicore_tick_wakeup_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // core [2:0], source_core [5:3], delay [21:6], vector [29:22], zero above
   input  logic [mtws_pkg::REQ_DATA_W-1:0]     req_tdata,
   // operation [1:0]
   input  logic [mtws_pkg::OP_W-1:0]           req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // target_core [2:0], ipi_vector [10:3], core_ticks [42:11],
   // slow_ticks [74:43], zero above
   output logic [mtws_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // ipi_valid [0]
   output logic [0:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mtws_pkg::ACTIVE_W-1:0]       csr_data
);
   import mtws_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                   state_ff, state_in;
   logic [ACTIVE_W-1:0]    active_ff, active_in;
   logic [SLOW_W-1:0]      slow_ff, slow_in;
   logic [COUNT_WIDTH-1:0] now_ff, now_in;
   scan_type               launch_ff, launch_in;
   logic                   pend_ff, pend_in;
   logic [CORE_W-1:0]      pend_tgt_ff, pend_tgt_in;
   logic [VEC_W-1:0]       pend_vec_ff, pend_vec_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ipi_ff, rsp_ipi_in;
   logic [CORE_W-1:0]      rsp_tgt_ff, rsp_tgt_in;
   logic [VEC_W-1:0]       rsp_vec_ff, rsp_vec_in;
   logic [COUNT_WIDTH-1:0] rsp_ticks_ff, rsp_ticks_in;
   logic [SLOW_W-1:0]      rsp_slow_ff, rsp_slow_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Request decode.
   logic [OP_W-1:0]    op;
   logic [CORE_W-1:0]  req_core, req_src, rd_idx;
   logic [DELAY_W-1:0] req_delay;
   logic [VEC_W-1:0]   req_vec;
   logic               accept, in_range;

   assign op        = req_tuser;
   assign req_core  = req_tdata[REQ_CORE_LO +: CORE_W];
   assign req_src   = req_tdata[REQ_SRC_LO +: CORE_W];
   assign req_delay = req_tdata[REQ_DELAY_LO +: DELAY_W];
   assign req_vec   = req_tdata[REQ_VEC_LO +: VEC_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_range   = ({1'b0, req_core} < (CORE_W + 1)'(NUM_CORES))
                       && ((op != OP_ARM) || ({1'b0, req_src} < (CORE_W + 1)'(NUM_CORES)));
   assign rd_idx     = (op == OP_ARM) ? req_src : req_core;

   // Cell row.
   scan_type               chain [NUM_CORES+1];
   hit_type                hits [NUM_CORES];
   logic [COUNT_WIDTH-1:0] counts [NUM_CORES];
   logic [RES_W-1:0]       residues [NUM_CORES];
   logic [NUM_CORES-1:0]   wr_en;
   cell_wr_type            wr;
   logic                   advance;

   assign chain[0] = launch_ff;

   for (genvar g = 0; g < NUM_CORES; g++) begin : g_cell
      assign wr_en[g] = accept && in_range && (req_core == CORE_W'(g));
      mtws_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cell_index   (CORE_W'(g)),
         .active_cores (active_ff),
         .wr_en        (wr_en[g]),
         .wr           (wr),
         .advance      (advance),
         .scan_in      (chain[g]),
         .scan_out     (chain[g+1]),
         .hit          (hits[g]),
         .count        (counts[g]),
         .residue      (residues[g])
      );
   end

   // Counter update for the addressed core.
   logic [COUNT_WIDTH-1:0] cnt_rd, now_val;
   logic [RES_W-1:0]       res_rd, res_nxt;

   assign cnt_rd  = counts[rd_idx];
   assign res_rd  = residues[rd_idx];
   assign now_val = cnt_rd + COUNT_WIDTH'(1);
   // The residue tracks the count modulo the slow divisor; a wrap of the
   // count to zero lands on a multiple as well.
   assign res_nxt = ((now_val == '0) || (res_rd == RES_LAST)) ? '0 : res_rd + RES_W'(1);

   always_comb begin
      wr.arm       = (op == OP_ARM);
      wr.clear     = (op == OP_CLEAR);
      wr.tick      = (op == OP_TICK);
      wr.wake_time = cnt_rd + COUNT_WIDTH'(req_delay);
      wr.source    = req_src;
      wr.vector    = req_vec;
      wr.count     = now_val;
      wr.residue   = res_nxt;
   end

   // Merge the cell hits; at most one cell holds the token.
   hit_type hit_any;
   always_comb begin
      hit_any = '0;
      for (int i = 0; i < NUM_CORES; i++) begin
         hit_any = hit_any | hits[i];
      end
   end

   logic end_valid, need_emit, can_emit, emit;
   assign end_valid = chain[NUM_CORES].valid;
   assign need_emit = (hit_any.hit && pend_ff) || end_valid;
   assign can_emit  = !rsp_valid_ff || rsp_tready;
   assign advance   = !(need_emit && !can_emit);
   assign emit      = need_emit && can_emit;

   logic tick_go;
   assign tick_go = accept && in_range && (op == OP_TICK);

   always_comb begin
      state_in     = state_ff;
      slow_in      = slow_ff;
      now_in       = now_ff;
      launch_in    = launch_ff;
      pend_in      = pend_ff;
      pend_tgt_in  = pend_tgt_ff;
      pend_vec_in  = pend_vec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ipi_in   = rsp_ipi_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_vec_in   = rsp_vec_ff;
      rsp_ticks_in = rsp_ticks_ff;
      rsp_slow_in  = rsp_slow_ff;
      rsp_last_in  = rsp_last_ff;
      active_in    = (csr_valid && csr_ready) ? csr_data : active_ff;

      if (advance) begin
         launch_in.valid = 1'b0;
      end
      if (tick_go) begin
         state_in        = ST_SCAN;
         now_in          = now_val;
         launch_in.valid = 1'b1;
         launch_in.core  = req_core;
         launch_in.now   = now_val;
         if (res_nxt == '0) begin
            slow_in = slow_ff + SLOW_W'(1);
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_ticks_in = now_ff;
         rsp_slow_in  = slow_ff;
         rsp_last_in  = end_valid;
         rsp_ipi_in   = pend_ff;
         rsp_tgt_in   = pend_ff ? pend_tgt_ff : '0;
         rsp_vec_in   = pend_ff ? pend_vec_ff : '0;
      end

      if (advance) begin
         if (hit_any.hit) begin
            pend_in     = 1'b1;
            pend_tgt_in = hit_any.target;
            pend_vec_in = hit_any.vector;
         end
         if (end_valid) begin
            pend_in  = 1'b0;
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         active_ff       <= ACTIVE_RESET;
         slow_ff         <= '0;
         launch_ff       <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         active_ff       <= active_in;
         slow_ff         <= slow_in;
         launch_ff       <= launch_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      pend_tgt_ff    <= pend_tgt_in;
      pend_vec_ff    <= pend_vec_in;
      rsp_ipi_ff     <= rsp_ipi_in;
      rsp_tgt_ff     <= rsp_tgt_in;
      rsp_vec_ff     <= rsp_vec_in;
      rsp_ticks_ff   <= rsp_ticks_in;
      rsp_slow_ff    <= rsp_slow_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ipi_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_USED_W)'(0), rsp_slow_ff, rsp_ticks_ff,
                        rsp_vec_ff, rsp_tgt_ff};

   logic [NUM_CORES:0] token_bits;
   always_comb begin
      for (int i = 0; i <= NUM_CORES; i++) begin
         token_bits[i] = chain[i].valid;
      end
   end

   // The scan token is never duplicated along the row.
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_bits))
      else $error("more than one scan token in the cell row");

   // While idle no token is in flight and nothing is pending.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (token_bits == '0) && !pend_ff)
      else $error("scan state left behind while idle");

   // Closing a tick returns to idle with a last result loaded.
   a_close: assert property (@(posedge clock) disable iff (reset)
      (end_valid && advance) |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("tick did not close with a last result");

   // An accepted tick moves to the scan state with a scan token launched.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      tick_go |=> (state_ff == ST_SCAN) && launch_ff.valid)
      else $error("tick did not launch a scan");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the multicore tick wakeup scheduler.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtws_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_PRINTS = 60;

   typedef struct packed {
      logic                   ipi;
      logic [CORE_W-1:0]      target;
      logic [VEC_W-1:0]       vector;
      logic [COUNT_WIDTH-1:0] ticks;
      logic [SLOW_W-1:0]      slow;
      logic                   last;
   } wake_result_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic [OP_W-1:0]         req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [0:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [ACTIVE_W-1:0]     csr_data;

   // Shadow state of the scheduler, updated on every accepted request and configuration write.
   logic [COUNT_WIDTH-1:0]  tick_count [NUM_CORES];
   logic [COUNT_WIDTH-1:0]  wake_at    [NUM_CORES];
   logic [CORE_W-1:0]       wake_src   [NUM_CORES];
   logic [VEC_W-1:0]        wake_vec   [NUM_CORES];
   logic [SLOW_W-1:0]       slow_count;
   logic [ACTIVE_W-1:0]     scan_limit;

   wake_result_type         pending_wakeups [$];
   int unsigned             mismatches;
   int unsigned             quiet_cycles;
   bit                      idle_on;
   int unsigned             rsp_hold_ask;
   int unsigned             rsp_hold_left;
   int unsigned             rsp_gap_left;

   logic [OP_W-1:0]         all_ops [4] = '{OP_TICK, OP_OTHER, OP_ARM, OP_CLEAR};

   multicore_tick_wakeup_scheduler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
   endtask

   // Applies one accepted request to the shadow state and queues its results.
   task automatic predict_wakeups(input logic [OP_W-1:0] op, input logic [CORE_W-1:0] core,
                                  input logic [CORE_W-1:0] src,
                                  input logic [DELAY_W-1:0] delay,
                                  input logic [VEC_W-1:0] vec);
      logic [COUNT_WIDTH-1:0] now;
      int                     scan;
      wake_result_type        hits [$];
      wake_result_type        r;
      case (op)
         OP_ARM: begin
            wake_at[core]  = tick_count[src] + COUNT_WIDTH'(delay);
            wake_src[core] = src;
            wake_vec[core] = vec;
         end
         OP_CLEAR: begin
            wake_at[core]  = '0;
            wake_src[core] = '0;
         end
         OP_TICK: begin
            now = tick_count[core] + 1'b1;
            tick_count[core] = now;
            if (now % SLOW_DIVISOR == 0)
               slow_count = slow_count + 1'b1;
            scan = (int'(scan_limit) > NUM_CORES) ? NUM_CORES : int'(scan_limit);
            for (int i = 0; i < scan; i++) begin
               if (i != int'(core) && wake_src[i] == core && wake_at[i] < now) begin
                  r = '{1'b1, CORE_W'(i), wake_vec[i], now, slow_count, 1'b0};
                  hits.push_back(r);
               end
            end
            if (hits.size() == 0)
               hits.push_back('{1'b0, '0, '0, now, slow_count, 1'b0});
            hits[hits.size()-1].last = 1'b1;
            foreach (hits[k])
               pending_wakeups.push_back(hits[k]);
         end
         default: ;
      endcase
   endtask

   // Request and configuration monitor.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            scan_limit = csr_data;
         if (req_tvalid && req_tready)
            predict_wakeups(req_tuser, req_tdata[REQ_CORE_LO +: CORE_W],
                            req_tdata[REQ_SRC_LO +: CORE_W],
                            req_tdata[REQ_DELAY_LO +: DELAY_W],
                            req_tdata[REQ_VEC_LO +: VEC_W]);
      end
   end

   // Result checker: every transfer is matched against the oldest expectation.
   always @(posedge clock) begin : result_check
      wake_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_wakeups.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[31:0], 32'd0);
         end else begin
            want = pending_wakeups.pop_front();
            if (rsp_tuser[0] !== want.ipi)
               report_mismatch("ipi_valid", 32'(rsp_tuser[0]), 32'(want.ipi));
            if (rsp_tdata[RSP_TGT_LO +: CORE_W] !== want.target)
               report_mismatch("target_core", 32'(rsp_tdata[RSP_TGT_LO +: CORE_W]),
                               32'(want.target));
            if (rsp_tdata[RSP_VEC_LO +: VEC_W] !== want.vector)
               report_mismatch("ipi_vector", 32'(rsp_tdata[RSP_VEC_LO +: VEC_W]),
                               32'(want.vector));
            if (rsp_tdata[RSP_TICKS_LO +: COUNT_WIDTH] !== want.ticks)
               report_mismatch("core_ticks", rsp_tdata[RSP_TICKS_LO +: COUNT_WIDTH],
                               want.ticks);
            if (rsp_tdata[RSP_SLOW_LO +: SLOW_W] !== want.slow)
               report_mismatch("slow_ticks", rsp_tdata[RSP_SLOW_LO +: SLOW_W], want.slow);
            if (rsp_tlast !== want.last)
               report_mismatch("last", 32'(rsp_tlast), 32'(want.last));
            if (rsp_tdata[RSP_DATA_W-1:RSP_USED_W] !== '0)
               report_mismatch("tdata padding", 32'(rsp_tdata[RSP_DATA_W-1:RSP_USED_W]),
                               32'd0);
         end
      end
   end

   // Result receiver: random stall bursts plus a long hold-off on request.
   always @(posedge clock) begin
      if (rsp_hold_ask != 0) begin
         rsp_hold_left = rsp_hold_ask;
         rsp_hold_ask = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_gap_left != 0) begin
         rsp_tready <= 1'b0;
         rsp_gap_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         rsp_gap_left = $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offers one request; valid stays high after the transfer so that a
   // following request can go out back to back.
   task automatic send_item(input logic [OP_W-1:0] op, input int core, input int src,
                            input logic [DELAY_W-1:0] delay, input logic [VEC_W-1:0] vec);
      logic [REQ_DATA_W-1:0] word;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      word = '0;
      word[REQ_CORE_LO +: CORE_W]   = CORE_W'(core);
      word[REQ_SRC_LO +: CORE_W]    = CORE_W'(src);
      word[REQ_DELAY_LO +: DELAY_W] = delay;
      word[REQ_VEC_LO +: VEC_W]     = vec;
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_tick(input int core);
      send_item(OP_TICK, core, $urandom_range(0, 7), DELAY_W'($urandom),
                VEC_W'($urandom));
   endtask

   // Waits until every expected result has come and the block has settled.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_wakeups.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [ACTIVE_W-1:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Mostly short delays so that wakeups fire, with the extremes now and then.
   function automatic logic [DELAY_W-1:0] pick_delay();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return DELAY_W'($urandom_range(0, 6));
      else if (roll < 78)
         return '1;
      else if (roll < 85)
         return '0;
      return DELAY_W'($urandom);
   endfunction

   // Reset entries point at core 0, so the first tick there wakes all others.
   task automatic test_reset_entries();
      send_tick(0);
      send_tick(3);
      send_item(OP_OTHER, 7, 7, '1, '1);
      send_item(OP_OTHER, 0, 0, '0, '0);
   endtask

   task automatic test_arm_clear();
      send_item(OP_ARM, 2, 3, 16'd0, 8'hFF);
      send_item(OP_ARM, 4, 3, 16'hFFFF, 8'hA5);
      send_item(OP_ARM, 5, 5, 16'd0, 8'h5A);
      send_item(OP_ARM, 6, 3, 16'd2, 8'h01);
      // Wake time equal to the new count must not fire.
      send_tick(3);
      send_tick(3);
      send_tick(3);
      // A core never wakes itself.
      send_tick(5);
      // A cleared entry falls back to core 0 but keeps its vector.
      send_item(OP_CLEAR, 2, 6, 16'h1234, 8'h77);
      send_tick(0);
   endtask

   task automatic test_scan_length();
      write_active(4'd0);
      send_tick(0);
      write_active(4'd1);
      send_item(OP_ARM, 0, 1, 16'd0, 8'h3C);
      send_item(OP_ARM, 7, 1, 16'd0, 8'hC3);
      send_tick(1);
      write_active(4'd7);
      send_tick(1);
      write_active(4'd15);
      send_tick(1);
   endtask

   // Arm-then-tick sequences with random content, mixed with noise items.
   task automatic random_items(input int count);
      int sent;
      int target;
      int src;
      int ticks;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) < 7) begin
            src = $urandom_range(0, 7);
            target = $urandom_range(0, 7);
            if ($urandom_range(0, 7) != 0 && target == src)
               target = (target + 1) % NUM_CORES;
            send_item(OP_ARM, target, src, pick_delay(), VEC_W'($urandom));
            ticks = $urandom_range(1, 6);
            sent += ticks + 1;
            repeat (ticks) begin
               if ($urandom_range(0, 9) == 0)
                  send_item(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7),
                            DELAY_W'($urandom), VEC_W'($urandom));
               else
                  send_tick(src);
            end
         end else begin
            send_item(all_ops[$urandom_range(0, 3)], $urandom_range(0, 7),
                      $urandom_range(0, 7), DELAY_W'($urandom), VEC_W'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_random_phases();
      write_active(4'd8);
      random_items(30);
      write_active(ACTIVE_W'($urandom_range(0, 15)));
      random_items(30);
      write_active(4'd1);
      random_items(30);
      write_active(4'd15);
      random_items(30);
   endtask

   // Drives one core past a multiple of 100 so the slow counter advances.
   task automatic test_slow_count();
      write_active(ACTIVE_RESET);
      while (tick_count[6] < COUNT_WIDTH'(SLOW_DIVISOR + 1)) begin
         if ($urandom_range(0, 9) == 0)
            send_item(OP_ARM, $urandom_range(0, 7), 6, pick_delay(), VEC_W'($urandom));
         else
            send_tick(6);
      end
   endtask

   // The receiver stops for a long stretch while ticks keep coming.
   task automatic test_backpressure();
      wait_idle();
      rsp_hold_ask = 150;
      repeat (12) send_tick($urandom_range(0, 7));
   endtask

   task automatic test_streaming();
      wait_idle();
      idle_on = 1'b0;
      random_items(30);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_OTHER;
      csr_valid = 1'b0;
      csr_data = ACTIVE_RESET;
      rsp_hold_ask = 0;
      rsp_hold_left = 0;
      rsp_gap_left = 0;
      mismatches = 0;
      quiet_cycles = 0;
      idle_on = 1'b1;
      for (int i = 0; i < NUM_CORES; i++) begin
         tick_count[i] = '0;
         wake_at[i] = '0;
         wake_src[i] = '0;
         wake_vec[i] = '0;
      end
      slow_count = '0;
      scan_limit = ACTIVE_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_entries();
      test_arm_clear();
      test_scan_length();
      test_random_phases();
      test_slow_count();
      test_backpressure();
      test_streaming();
      wait_idle();

      if (mismatches == 0 && pending_wakeups.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
